@@ rtl/core/anxb_pkg.sv @@
// Shared types and constants for the Annex-B NAL splitter.
package anxb_pkg;

  localparam int unsigned HoldDepth     = 4;
  localparam int unsigned SliceNumWidth = 32;

  localparam logic [7:0] StartCodeTail = 8'h01;
  localparam logic [4:0] TypeSlice     = 5'd1;
  localparam logic [4:0] TypeIdr       = 5'd5;
  localparam logic [4:0] TypeSps       = 5'd7;
  localparam logic [4:0] TypePps       = 5'd8;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]               payload_byte;
    logic [4:0]               unit_type;
    logic                     first_of_unit;
    logic                     last_of_unit;
    logic                     keyframe;
    logic [SliceNumWidth-1:0] slice_number;
  } out_beat_t;

endpackage

@@ rtl/core/annexb_nal_splitter.sv @@
// Annex-B NAL unit splitter: start code search, holdback, classification and result queue.
// Flow: a byte enters an input register, is processed in the next cycle and its results are
// queued for the output; payload bytes lag the stream by a 4-byte holdback.
// Throughput: one byte per cycle; a unit close writes up to 4 results at once into a 16-entry
// result queue drained one per cycle, and input ready drops while more than 8 results wait.
// Reset clears the holdback, the unit state, the SPS/PPS flags, the slice counter and the queue.
module annexb_nal_splitter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  anxb_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output anxb_pkg::out_beat_t out_data_o
);
  import anxb_pkg::*;

  localparam int unsigned QDepth      = 16;
  localparam int unsigned QAw         = $clog2(QDepth);
  localparam int unsigned QCntW       = $clog2(QDepth + 1);
  localparam int unsigned AcceptLimit = QDepth / 2;
  localparam int unsigned HcW         = $clog2(HoldDepth + 1);
  localparam int unsigned HiW         = $clog2(HoldDepth);

  // input register
  logic     s1_valid_q;
  in_beat_t s1_data_q;

  // parser state
  logic [7:0]             hold_q [HoldDepth];
  logic [7:0]             hold_d [HoldDepth];
  logic [HcW-1:0]         hold_cnt_q, hold_cnt_d;
  logic                   inside_q, inside_d;
  logic                   await_q, await_d;
  logic [4:0]             type_q, type_d;
  logic                   fwd_q, fwd_d;
  logic                   sps_q, sps_d;
  logic                   pps_q, pps_d;
  logic [COUNT_WIDTH-1:0] slice_cnt_q, slice_cnt_d;

  // result queue
  out_beat_t        q_mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] q_cnt_q;

  logic           start_hit, strip3, do_close, mark_last;
  logic [HcW-1:0] keep, n_emit;
  logic [7:0]     b;
  logic [HoldDepth-1:0] zero;
  out_beat_t      ent [HoldDepth];
  logic           pop, accept;

  assign b      = s1_data_q.stream_byte;
  assign accept = in_valid_i & in_ready_o;
  assign pop    = out_valid_o & out_ready_i;

  always_comb begin
    for (int i = 0; i < HoldDepth; i++) begin
      zero[i] = (hold_q[i] == 8'h00);
    end
    case (hold_cnt_q)
      HcW'(2): start_hit = zero[1] & zero[0];
      HcW'(3): start_hit = zero[2] & zero[1];
      HcW'(4): start_hit = zero[3] & zero[2];
      default: start_hit = 1'b0;
    endcase
    case (hold_cnt_q)
      HcW'(3): strip3 = zero[0];
      HcW'(4): strip3 = zero[1];
      default: strip3 = 1'b0;
    endcase
  end

  always_comb begin
    hold_d      = hold_q;
    hold_cnt_d  = hold_cnt_q;
    inside_d    = inside_q;
    await_d     = await_q;
    type_d      = type_q;
    fwd_d       = fwd_q;
    sps_d       = sps_q;
    pps_d       = pps_q;
    slice_cnt_d = slice_cnt_q;
    do_close    = 1'b0;
    keep        = '0;
    n_emit      = '0;
    mark_last   = 1'b0;

    if (s1_valid_q) begin
      if (s1_data_q.end_of_stream || (b == StartCodeTail && start_hit)) begin
        do_close = inside_q;
        keep     = s1_data_q.end_of_stream ? hold_cnt_q
                                           : hold_cnt_q - (strip3 ? HcW'(3) : HcW'(2));
        for (int i = 0; i < HoldDepth; i++) begin
          hold_d[i] = 8'h00;
        end
        hold_cnt_d = '0;
        inside_d   = ~s1_data_q.end_of_stream;
        await_d    = ~s1_data_q.end_of_stream;
        type_d     = '0;
        fwd_d      = 1'b0;
      end else begin
        // classify on the header byte
        if (inside_q && await_q && hold_cnt_q == '0) begin
          type_d = b[4:0];
          fwd_d  = (b[4:0] == TypeSlice) || (b[4:0] == TypeIdr) ||
                   (b[4:0] == TypeSps) || (b[4:0] == TypePps);
          if (b[4:0] == TypeSps) sps_d = 1'b1;
          if (b[4:0] == TypePps) pps_d = 1'b1;
        end
        if (hold_cnt_q == HcW'(HoldDepth)) begin
          // release the oldest held byte and advance
          if (inside_q && fwd_q) begin
            n_emit  = HcW'(1);
            await_d = 1'b0;
          end
          for (int i = 0; i < HoldDepth - 1; i++) begin
            hold_d[i] = hold_q[i+1];
          end
          hold_d[HoldDepth-1] = b;
        end else begin
          hold_d[hold_cnt_q[HiW-1:0]] = b;
          hold_cnt_d = hold_cnt_q + HcW'(1);
        end
      end

      if (do_close && fwd_q && keep != '0) begin
        n_emit    = keep;
        mark_last = 1'b1;
        if (type_q == TypeSlice || type_q == TypeIdr) begin
          slice_cnt_d = slice_cnt_q + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < HoldDepth; i++) begin
      ent[i].payload_byte  = hold_q[i];
      ent[i].unit_type     = type_q;
      ent[i].first_of_unit = await_q && (i == 0);
      ent[i].last_of_unit  = mark_last && (HcW'(i + 1) == n_emit);
      ent[i].keyframe      = (type_q == TypeIdr) && sps_q && pps_q;
      ent[i].slice_number  = SliceNumWidth'(slice_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      hold_cnt_q  <= '0;
      inside_q    <= 1'b0;
      await_q     <= 1'b0;
      type_q      <= '0;
      fwd_q       <= 1'b0;
      sps_q       <= 1'b0;
      pps_q       <= 1'b0;
      slice_cnt_q <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      q_cnt_q     <= '0;
      for (int i = 0; i < HoldDepth; i++) begin
        hold_q[i] <= 8'h00;
      end
    end else begin
      s1_valid_q  <= accept;
      hold_q      <= hold_d;
      hold_cnt_q  <= hold_cnt_d;
      inside_q    <= inside_d;
      await_q     <= await_d;
      type_q      <= type_d;
      fwd_q       <= fwd_d;
      sps_q       <= sps_d;
      pps_q       <= pps_d;
      slice_cnt_q <= slice_cnt_d;
      wr_ptr_q    <= wr_ptr_q + QAw'(n_emit);
      if (pop) rd_ptr_q <= rd_ptr_q + QAw'(1);
      q_cnt_q     <= q_cnt_q + QCntW'(n_emit) - QCntW'(pop);
    end
  end

  // payload registers: input beat and queue entries
  always_ff @(posedge clk_i) begin
    if (accept) s1_data_q <= in_data_i;
    for (int i = 0; i < HoldDepth; i++) begin
      if (HcW'(i) < n_emit) q_mem_q[wr_ptr_q + QAw'(i)] <= ent[i];
    end
  end

  assign in_ready_o  = (q_cnt_q <= QCntW'(AcceptLimit));
  assign out_valid_o = (q_cnt_q != '0);
  assign out_data_o  = q_mem_q[rd_ptr_q];

endmodule
